FILE: hdl/ascf_pkg.sv
// ascf_pkg: shared constants and types for the ASCII command frame parser.
// No dependencies.
package ascf_pkg;

	localparam int FIELD_W          = 7;
	localparam int MAX_FIELD_DIGITS = 2;

	typedef logic [1:0]         kind_t;
	typedef logic [FIELD_W-1:0] field_t;

	localparam kind_t KIND_PARAMS  = 2'd0;
	localparam kind_t KIND_PAYLOAD = 2'd1;
	localparam kind_t KIND_ERROR   = 2'd2;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;
	localparam logic [3:0] RADIX      = 4'd10;

	// a frame holds four spaces: after the command and after each field
	localparam logic [2:0] FIELD_SPACES = 3'd4;
	localparam field_t     FIELD_MAX    = 7'd127;

endpackage

FILE: hdl/ascii_command_frame_parser.sv
// ascii_command_frame_parser: text command frame parser, one byte per beat.
// Latency: a result is registered at the edge that accepts the byte that causes it,
// and is offered from the next cycle on. Throughput: one byte per cycle while no held
// result blocks in_ready, set by the single state update that follows each accepted
// byte; the output register lets a new byte in while a result is being taken. Reset
// (arst_n, async, active low) puts the parser in idle, waiting for a command byte,
// with no result pending. Depends on ascf_pkg.
module ascii_command_frame_parser #(
	parameter int MAX_FIELD_DIGITS = ascf_pkg::MAX_FIELD_DIGITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ascf_pkg::kind_t      kind,
	output logic [7:0]           command,
	output ascf_pkg::field_t     sector,
	output ascf_pkg::field_t     offset,
	output ascf_pkg::field_t     count,
	output logic [7:0]           payload_byte,
	output logic                 last
);
	import ascf_pkg::*;

	// digit counter must reach MAX_FIELD_DIGITS itself
	localparam int DIGIT_W = $clog2(MAX_FIELD_DIGITS + 1);
	localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(MAX_FIELD_DIGITS);

	// ---------------------------------------------------------------
	// Parser state
	// ---------------------------------------------------------------
	logic               in_frame_q;
	logic [7:0]         command_q;
	logic [2:0]         spaces_q;      // spaces seen so far in the frame
	logic [DIGIT_W-1:0] digits_q;      // digits in the open field
	field_t             acc_q;         // value of the open field
	field_t             sector_q;
	field_t             offset_q;
	field_t             count_q;
	field_t             left_q;        // payload bytes still to come

	// next-state values
	logic               in_frame_d;
	logic [7:0]         command_d;
	logic [2:0]         spaces_d;
	logic [DIGIT_W-1:0] digits_d;
	field_t             acc_d;
	field_t             sector_d;
	field_t             offset_d;
	field_t             count_d;
	field_t             left_d;

	// result built for the accepted byte
	logic               res_fire;
	kind_t              res_kind;
	field_t             res_sector;
	field_t             res_offset;
	field_t             res_count;
	logic [7:0]         res_payload;
	logic               res_last;

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic               out_valid_q;
	kind_t              kind_q;
	logic [7:0]         command_out_q;
	field_t             sector_out_q;
	field_t             offset_out_q;
	field_t             count_out_q;
	logic [7:0]         payload_q;
	logic               last_q;

	logic               in_fire;

	// Take a byte whenever the result slot is empty or being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Digit decode and decimal accumulate: acc*10 + d, saturating at 127.
	logic        is_space;
	logic        is_digit;
	logic [3:0]  digit_val;
	logic [10:0] acc_times_ten;
	logic [10:0] acc_sum;
	field_t      acc_next;
	field_t      left_dec;

	assign is_space      = (rx_byte == SPACE_CHAR);
	assign is_digit      = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
	assign digit_val     = 4'(rx_byte - DIGIT_ZERO);
	assign acc_times_ten = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign acc_sum       = acc_times_ten + {7'd0, digit_val};
	assign acc_next      = (acc_sum > {4'd0, FIELD_MAX}) ? FIELD_MAX : acc_sum[FIELD_W-1:0];
	assign left_dec      = (left_q != '0) ? (left_q - 7'd1) : left_q;

	always_comb begin
		in_frame_d  = in_frame_q;
		command_d   = command_q;
		spaces_d    = spaces_q;
		digits_d    = digits_q;
		acc_d       = acc_q;
		sector_d    = sector_q;
		offset_d    = offset_q;
		count_d     = count_q;
		left_d      = left_q;

		res_fire    = 1'b0;
		res_kind    = KIND_ERROR;
		res_sector  = '0;
		res_offset  = '0;
		res_count   = '0;
		res_payload = '0;
		res_last    = 1'b1;

		priority if (!in_frame_q) begin
			// any byte while idle opens a frame as its command letter
			command_d  = rx_byte;
			in_frame_d = 1'b1;
			spaces_d   = '0;
			digits_d   = '0;
			acc_d      = '0;
			left_d     = '0;
		end else if (spaces_q >= FIELD_SPACES) begin
			// payload pass-through
			left_d      = left_dec;
			res_fire    = 1'b1;
			res_kind    = KIND_PAYLOAD;
			res_sector  = sector_q;
			res_offset  = offset_q;
			res_count   = count_q;
			res_payload = rx_byte;
			res_last    = (left_dec == '0);
			if (left_dec == '0) begin
				in_frame_d = 1'b0;
				spaces_d   = '0;
			end
		end else if (spaces_q == 3'd0) begin
			// the byte after the command must be a space
			if (is_space) begin
				spaces_d = 3'd1;
			end else begin
				res_fire = 1'b1;
			end
		end else if (is_space) begin
			if (digits_q == '0) begin
				res_fire = 1'b1;   // empty field
			end else begin
				if (spaces_q == 3'd1) begin
					sector_d = acc_q;
				end else if (spaces_q == 3'd2) begin
					offset_d = acc_q;
				end else begin
					count_d = acc_q;
				end
				spaces_d = spaces_q + 3'd1;
				digits_d = '0;
				acc_d    = '0;
				if (spaces_q + 3'd1 >= FIELD_SPACES) begin
					// count field closed: report parameters
					res_fire   = 1'b1;
					res_kind   = KIND_PARAMS;
					res_sector = sector_q;
					res_offset = offset_q;
					res_count  = acc_q;
					res_last   = (acc_q == '0);
					if (acc_q == '0) begin
						in_frame_d = 1'b0;
						spaces_d   = '0;
					end else begin
						left_d = acc_q;
					end
				end
			end
		end else if (is_digit) begin
			if (digits_q >= DIGIT_LIMIT) begin
				res_fire = 1'b1;   // too many digits
			end else begin
				acc_d    = acc_next;
				digits_d = digits_q + 1'b1;
			end
		end else begin
			res_fire = 1'b1;       // stray character inside a field
		end

		// every error drops back to idle
		if (res_fire && res_kind == KIND_ERROR) begin
			in_frame_d = 1'b0;
			spaces_d   = '0;
			digits_d   = '0;
			acc_d      = '0;
			left_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			command_q  <= '0;
			spaces_q   <= '0;
			digits_q   <= '0;
			acc_q      <= '0;
			sector_q   <= '0;
			offset_q   <= '0;
			count_q    <= '0;
			left_q     <= '0;
		end else if (in_fire) begin
			in_frame_q <= in_frame_d;
			command_q  <= command_d;
			spaces_q   <= spaces_d;
			digits_q   <= digits_d;
			acc_q      <= acc_d;
			sector_q   <= sector_d;
			offset_q   <= offset_d;
			count_q    <= count_d;
			left_q     <= left_d;
		end
	end

	// result slot: loaded by a byte that yields a result, emptied on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_fire) begin
			kind_q        <= res_kind;
			command_out_q <= command_q;
			sector_out_q  <= res_sector;
			offset_out_q  <= res_offset;
			count_out_q   <= res_count;
			payload_q     <= res_payload;
			last_q        <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign command      = command_out_q;
	assign sector       = sector_out_q;
	assign offset       = offset_out_q;
	assign count        = count_out_q;
	assign payload_byte = payload_q;
	assign last         = last_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// in the payload phase there is always at least one byte left
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(in_frame_q && spaces_q >= FIELD_SPACES) |-> (left_q != '0))
		else $error("payload phase with no bytes left");

	// space count never passes the frame's four
	a_spaces_max: assert property (@(posedge clk) disable iff (!arst_n)
		spaces_q <= FIELD_SPACES)
		else $error("space count out of range");

	// an idle byte always opens a frame and yields no result
	a_idle_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !in_frame_q) |=> (in_frame_q && !out_valid_q))
		else $error("command byte did not open a frame");

	// an error result is final and carries cleared fields
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_ERROR) |->
		(last_q && sector_out_q == '0 && offset_out_q == '0 &&
		 count_out_q == '0 && payload_q == '0))
		else $error("malformed error result");

	// a parameters result is final exactly when the count is zero
	a_params_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_PARAMS) |-> (last_q == (count_out_q == '0)))
		else $error("parameters result last flag wrong");

endmodule

FILE: tb/frame_check_pkg.sv
// frame_check_pkg: expected-result tracker for the ASCII command frame parser bench.
// Mirrors the parser state on every accepted input beat and checks result beats in order.
// Depends on ascf_pkg.
package frame_check_pkg;
	import ascf_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] command;
		field_t     sector;
		field_t     offset;
		field_t     count;
		logic [7:0] payload_byte;
		logic       last;
	} frame_result_t;

	class frame_tracker;
		// mirrored parser state
		bit         in_frame;
		logic [7:0] command_q;
		logic [2:0] spaces;
		int         digits;
		int         acc;
		field_t     sector_q;
		field_t     offset_q;
		field_t     count_q;
		int         payload_left;

		frame_result_t results_due[$];
		int            mismatches;
		int            beats_in;
		int            beats_out;
		int            kind_seen[3];

		function new();
			mismatches = 0;
			beats_in   = 0;
			beats_out  = 0;
			kind_seen  = '{0, 0, 0};
			go_idle();
			command_q = 8'h00;
			sector_q  = '0;
			offset_q  = '0;
			count_q   = '0;
		endfunction

		function void go_idle();
			in_frame     = 1'b0;
			spaces       = '0;
			digits       = 0;
			acc          = 0;
			payload_left = 0;
		endfunction

		function void push(kind_t k, field_t s, field_t o, field_t c, logic [7:0] p, logic l);
			frame_result_t r;
			r.kind         = k;
			r.command      = command_q;
			r.sector       = s;
			r.offset       = o;
			r.count        = c;
			r.payload_byte = p;
			r.last         = l;
			results_due.push_back(r);
		endfunction

		function void format_error();
			push(KIND_ERROR, '0, '0, '0, 8'h00, 1'b1);
			go_idle();
		endfunction

		// advance the mirror by one accepted byte, queue any result it causes
		function void take_byte(logic [7:0] b);
			beats_in++;
			if (!in_frame) begin
				command_q    = b;
				in_frame     = 1'b1;
				spaces       = '0;
				digits       = 0;
				acc          = 0;
				payload_left = 0;
			end else if (spaces >= FIELD_SPACES) begin
				if (payload_left > 0)
					payload_left--;
				push(KIND_PAYLOAD, sector_q, offset_q, count_q, b, payload_left == 0);
				if (payload_left == 0)
					go_idle();
			end else if (spaces == 3'd0) begin
				if (b != SPACE_CHAR)
					format_error();
				else
					spaces = 3'd1;
			end else if (b == SPACE_CHAR) begin
				if (digits == 0) begin
					format_error();
				end else begin
					case (spaces)
						3'd1: sector_q = field_t'(acc);
						3'd2: offset_q = field_t'(acc);
						default: count_q = field_t'(acc);
					endcase
					spaces = spaces + 3'd1;
					digits = 0;
					acc    = 0;
					if (spaces >= FIELD_SPACES) begin
						push(KIND_PARAMS, sector_q, offset_q, count_q, 8'h00, count_q == 0);
						if (count_q == 0)
							go_idle();
						else
							payload_left = count_q;
					end
				end
			end else if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
				if (digits >= MAX_FIELD_DIGITS) begin
					format_error();
				end else begin
					acc = acc * int'(RADIX) + int'(b - DIGIT_ZERO);
					if (acc > int'(FIELD_MAX))
						acc = int'(FIELD_MAX);
					digits++;
				end
			end else begin
				format_error();
			end
		endfunction

		function bit idle();
			return !in_frame;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function string show(frame_result_t r);
			return $sformatf("kind=%0d cmd=%02h sec=%0d off=%0d cnt=%0d pay=%02h last=%0b",
				r.kind, r.command, r.sector, r.offset, r.count, r.payload_byte, r.last);
		endfunction

		function void compare_result(frame_result_t got);
			frame_result_t want;
			beats_out++;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result beat %0d with nothing due: %s", beats_out, show(got));
				return;
			end
			want = results_due.pop_front();
			kind_seen[want.kind]++;
			if (got.kind !== want.kind || got.command !== want.command ||
			    got.sector !== want.sector || got.offset !== want.offset ||
			    got.count !== want.count || got.payload_byte !== want.payload_byte ||
			    got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result beat %0d differs\n  expected %s\n  actual   %s",
						beats_out, show(want), show(got));
			end
		endfunction
	endclass

endpackage

FILE: tb/tb.sv
// tb: top-level bench for ascii_command_frame_parser, driving byte beats in and checking
// result beats against frame_tracker under random idling and back-pressure.
// Depends on ascf_pkg, frame_check_pkg and the parser RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ascf_pkg::*;
	import frame_check_pkg::*;

	localparam int BYTE_BUDGET  = 1100;
	localparam int HOLD_AT      = 300;   // long receiver hold-off starts here
	localparam int QUIET_FROM   = 500;   // no idling on either side in this window
	localparam int QUIET_TO     = 650;
	localparam int DRAIN_AT     = 700;   // sender waits for every due result here
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 10;

	// ways of breaking a well-formed frame header
	typedef enum int {FLIP_BYTE, EXTRA_DIGIT, DROP_BYTE} corrupt_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	kind_t      kind;
	logic [7:0] command;
	field_t     sector;
	field_t     offset;
	field_t     count;
	logic [7:0] payload_byte;
	logic       last;

	frame_tracker tracker;
	bit           hold_off_req;
	bit           no_idle;
	int           bytes_sent;

	ascii_command_frame_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.command      (command),
		.sector       (sector),
		.offset       (offset),
		.count        (count),
		.payload_byte (payload_byte),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly short, now and then long; zero in the quiet window
	function int pick_gap();
		if (no_idle)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// Offer one byte from the falling edge and hold it until a rising edge takes it.
	// With no gap drawn, valid stays high and the next call swaps the payload at the
	// next falling edge, so every caller must go straight to another send_byte or
	// lower valid itself before waiting on anything else.
	task send_byte(logic [7:0] b);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(b);
		bytes_sent++;
		gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// One frame: random command byte, three fields of one or two digits, then the
	// payload. About one frame in five gets its header broken in one place.
	task send_random_frame();
		logic [7:0] frame_q[$];
		int         v;
		int         hdr_len;
		int         pos;
		corrupt_t   how;
		frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(SPACE_CHAR);
		for (int f = 0; f < 3; f++) begin
			// count stays small most of the time to keep frames short
			if (f == 2)
				v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 6);
			else
				v = ($urandom_range(0, 3) == 0) ? 99 * $urandom_range(0, 1)
				                                : $urandom_range(0, 99);
			// a leading zero is legal, so single-digit values sometimes get two digits
			if (v >= 10 || $urandom_range(0, 1) == 1)
				frame_q.push_back(8'(DIGIT_ZERO + v / 10));
			frame_q.push_back(8'(DIGIT_ZERO + v % 10));
			frame_q.push_back(SPACE_CHAR);
		end
		hdr_len = frame_q.size();
		for (int i = 0; i < v; i++)
			frame_q.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) == 0) begin
			pos = $urandom_range(1, hdr_len - 1);
			how = corrupt_t'($urandom_range(0, 2));
			case (how)
				FLIP_BYTE: begin
					// bias toward the characters just around the digit range
					case ($urandom_range(0, 3))
						0: frame_q[pos] = DIGIT_ZERO - 8'd1;
						1: frame_q[pos] = DIGIT_NINE + 8'd1;
						2: frame_q[pos] = SPACE_CHAR;
						default: frame_q[pos] = 8'($urandom_range(0, 255));
					endcase
				end
				EXTRA_DIGIT: frame_q.insert(pos, 8'(DIGIT_ZERO + $urandom_range(0, 9)));
				default: frame_q.delete(pos);
			endcase
		end
		foreach (frame_q[i])
			send_byte(frame_q[i]);
	endtask

	// stimulus
	initial begin
		bit held;
		bit drained;
		int wait_cycles;
		int fails;
		tracker    = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = 8'h00;
		bytes_sent = 0;
		held       = 1'b0;
		drained    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: zero count with a null command byte, two-digit sector and offset with
		// payload bytes at both extremes, then each kind of format fault
		send_byte(8'h00);
		send_text(" 0 0 0 ");
		send_byte(8'hFF);
		send_text(" 99 99 2 ");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("RX");      // missing first space
		send_text("R :");     // non-digit in a field
		send_text("R  ");     // empty field
		send_text("R 100");   // one digit too many

		// random: mostly well-formed frames, some broken ones and loose noise
		while (bytes_sent < BYTE_BUDGET) begin
			if (!held && bytes_sent >= HOLD_AT) begin
				// receiver sits out a long stretch while bytes keep coming,
				// so the output register fills and in_ready drops
				hold_off_req = 1'b1;
				held         = 1'b1;
			end
			if (!drained && bytes_sent >= DRAIN_AT) begin
				// sender pause until everything due has been taken
				@(negedge clk);
				in_valid <= 1'b0;
				while (tracker.pending() != 0)
					@(posedge clk);
				drained = 1'b1;
			end
			no_idle = (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO);
			// finish whatever a broken frame left open before starting a clean one
			while (!tracker.idle())
				send_byte(8'($urandom));
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			else
				send_random_frame();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (tracker.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		fails = tracker.mismatches + tracker.pending();
		$display("covered %0d byte beats in, %0d result beats out (%0d params, %0d payload, %0d error)",
			tracker.beats_in, tracker.beats_out, tracker.kind_seen[KIND_PARAMS],
			tracker.kind_seen[KIND_PAYLOAD], tracker.kind_seen[KIND_ERROR]);
		$display("with a %0d-cycle receiver hold-off, one full drain pause and a no-idle stretch",
			LONG_HOLD);
		if (fails == 0)
			$display("ascii_command_frame_parser: match");
		else
			$display("ascii_command_frame_parser: mismatch");
		$finish;
	end

	// receiver: random stalls, plus the one long hold-off the stimulus asks for
	initial begin
		int stall_left;
		out_ready  = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready   <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// result beats are taken at the rising edge
	always @(posedge clk) begin : result_monitor
		frame_result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.kind         = kind;
			seen.command      = command;
			seen.sector       = sector;
			seen.offset       = offset;
			seen.count        = count;
			seen.payload_byte = payload_byte;
			seen.last         = last;
			tracker.compare_result(seen);
		end
	end

	// hard stop well past the slowest correct run
	initial begin
		#5_000_000;
		$display("ascii_command_frame_parser: mismatch");
		$finish;
	end

endmodule
